>>> hdl/varap_pkg.sv
package varap_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_WINDOW   = 16;
    localparam int MAX_CHANNELS = 4096;

    localparam int DATA_W = 32;
    localparam int SUM_W  = 40;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ADDR_W = 5;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_POOL = 1'b1;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_CHANNELS = 3'd1;
    localparam logic [2:0] REG_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_WIDTH    = 3'd3;
    localparam logic [2:0] REG_WIN_H    = 3'd4;
    localparam logic [2:0] REG_WIN_W    = 3'd5;
    localparam logic [2:0] REG_RELU     = 3'd6;

    // Configuration after zero and saturation clamps.
    typedef struct packed {
        logic        mode;
        logic        relu;
        logic [12:0] nch;
        logic [15:0] h;
        logic [10:0] w;
        logic [4:0]  kh;
        logic [4:0]  kw;
    } t_cfg;

    // Controller to datapath.
    typedef struct packed {
        logic             start;     // new item latched
        logic             clear;     // reset partial sum on first element of window
        logic             active;    // element falls inside a whole window
        logic             emit;      // window complete
        logic [COL_W-1:0] wc;        // window column
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic div_done;
    } t_sts;

    function automatic logic [15:0] clamp16(input logic [15:0] v, input logic [15:0] hi);
        logic [15:0] r;
        begin
            r = v;
            if (v == 16'd0) r = 16'd1;
            else if (v > hi) r = hi;
            return r;
        end
    endfunction

endpackage

>>> hdl/varap_ctrl.sv
module varap_ctrl
    import varap_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_cfg_wr,
    input  logic              i_in_fire,
    input  logic              i_out_free,
    input  t_sts              i_sts,
    output logic              o_ready,
    output logic              o_out_load,
    output logic              o_out_last,
    output t_cmd              o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ACC  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [COL_W-1:0] r_col, n_col;      // column position
    logic [4:0]       r_kc,  n_kc;       // column within window
    logic [COL_W-1:0] r_wc,  n_wc;       // window column
    logic [15:0]      r_row, n_row;
    logic [4:0]       r_kr,  n_kr;
    logic [11:0]      r_ch,  n_ch;
    logic             r_last, n_last;
    logic             r_emit, n_emit;

    // Window fits when the last row/col of this window is still inside the map.
    logic [16:0] row_lim;
    logic [11:0] col_lim;
    logic        row_ok, col_ok, last_wr, last_wc;
    always_comb begin
        row_lim = 17'(r_row) - 17'(r_kr) + 17'(i_cfg.kh);
        col_lim = 12'(r_col) - 12'(r_kc) + 12'(i_cfg.kw);
        row_ok  = row_lim <= 17'(i_cfg.h);
        col_ok  = col_lim <= 12'(i_cfg.w);
        last_wr = (row_lim + 17'(i_cfg.kh)) > 17'(i_cfg.h);
        last_wc = (col_lim + 12'(i_cfg.kw)) > 12'(i_cfg.w);
    end

    always_comb begin
        n_state = r_state;
        n_col = r_col; n_kc = r_kc; n_wc = r_wc;
        n_row = r_row; n_kr = r_kr; n_ch = r_ch;
        n_last = r_last; n_emit = r_emit;
        o_cmd = '0;
        o_cmd.wc = r_wc;
        o_out_load = 1'b0;
        o_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.start = 1'b1;
                    if (i_cfg.mode == MODE_ADD) begin
                        n_last = (17'(r_row) + 17'd1) >= 17'(i_cfg.h);
                        n_row  = n_last ? 16'd0 : r_row + 16'd1;
                        n_emit = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        o_cmd.active = row_ok && col_ok;
                        o_cmd.clear  = (r_kr == 5'd0) && (r_kc == 5'd0);
                        n_emit = row_ok && col_ok && (r_kr == i_cfg.kh - 5'd1)
                                 && (r_kc == i_cfg.kw - 5'd1);
                        n_last = (13'(r_ch) + 13'd1 >= i_cfg.nch) && last_wr && last_wc;
                        n_state = S_ACC;
                        // advance positions
                        if (12'(r_col) + 12'd1 >= 12'(i_cfg.w)) begin
                            n_col = '0; n_kc = '0; n_wc = '0;
                            if (17'(r_row) + 17'd1 >= 17'(i_cfg.h)) begin
                                n_row = '0; n_kr = '0;
                                n_ch = (13'(r_ch) + 13'd1 >= i_cfg.nch) ? 12'd0
                                                                        : r_ch + 12'd1;
                            end else begin
                                n_row = r_row + 16'd1;
                                if (r_kr == i_cfg.kh - 5'd1) begin
                                    n_kr = '0;
                                end else begin
                                    n_kr = r_kr + 5'd1;
                                end
                            end
                        end else begin
                            n_col = r_col + COL_W'(1);
                            if (r_kc == i_cfg.kw - 5'd1) begin
                                n_kc = '0; n_wc = r_wc + COL_W'(1);
                            end else begin
                                n_kc = r_kc + 5'd1;
                            end
                        end
                    end
                end
            end
            S_ACC: begin
                n_state = r_emit ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.emit = (r_state == S_ACC) && r_emit;
        if (i_cfg_wr) begin
            n_col = '0; n_kc = '0; n_wc = '0;
            n_row = '0; n_kr = '0; n_ch = '0;
        end
    end

    assign o_out_last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col <= '0; r_kc <= '0; r_wc <= '0;
            r_row <= '0; r_kr <= '0; r_ch <= '0;
            r_last <= 1'b0; r_emit <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col <= n_col; r_kc <= n_kc; r_wc <= n_wc;
            r_row <= n_row; r_kr <= n_kr; r_ch <= n_ch;
            r_last <= n_last; r_emit <= n_emit;
        end
    end

endmodule

>>> hdl/varap_dp.sv
module varap_dp
    import varap_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_cmd              i_cmd,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output t_sts              o_sts,
    output logic [DATA_W-1:0] o_result
);

    // Line store of partial window sums, reset to zero by first-element clear.
    logic [SUM_W-1:0] r_mem [MAX_WIDTH];
    logic [DATA_W-1:0] r_a;
    logic [COL_W-1:0]  r_wc;
    logic              r_act, r_clr;
    logic [SUM_W-1:0]  r_rd;
    logic [SUM_W-1:0]  sum_new;
    logic [DATA_W-1:0] r_res;

    // Restoring divider for |sum| / area.
    logic [SUM_W-1:0] r_quo, r_rem;
    logic [8:0]       r_den;
    logic [5:0]       r_cnt;
    logic             r_busy, r_neg;
    logic [SUM_W-1:0] rem_sh;
    logic [SUM_W-1:0] q_signed;
    logic [DATA_W-1:0] add_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a   <= i_a;
            r_wc  <= i_cmd.wc;
            r_act <= i_cmd.active;
            r_clr <= i_cmd.clear;
            r_rd  <= r_mem[i_cmd.wc];
        end
    end

    assign sum_new = (r_clr ? '0 : r_rd) + SUM_W'($signed(r_a));

    // Write back in the accumulate cycle, the cycle after start.
    logic r_wen;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wen <= 1'b0;
        else          r_wen <= i_cmd.start && i_cmd.active;
    end
    always_ff @(posedge i_clk) begin
        if (r_wen) r_mem[r_wc] <= sum_new;
    end

    assign rem_sh = {r_rem[SUM_W-2:0], r_quo[SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.emit) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(SUM_W);
            r_neg  <= sum_new[SUM_W-1];
            r_quo  <= sum_new[SUM_W-1] ? (~sum_new + SUM_W'(1)) : sum_new;
            r_rem  <= '0;
            r_den  <= 9'(i_cfg.kh) * 9'(i_cfg.kw);
        end else if (r_busy) begin
            if (rem_sh >= SUM_W'(r_den)) begin
                r_rem <= rem_sh - SUM_W'(r_den);
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    assign o_sts.div_done = !r_busy && (r_cnt == 6'd0);
    assign q_signed = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign add_res  = i_a + i_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && i_cfg.mode == MODE_ADD)
            r_res <= (i_cfg.relu && add_res[DATA_W-1]) ? '0 : add_res;
        else if (o_sts.div_done && i_cfg.mode == MODE_POOL)
            r_res <= q_signed[DATA_W-1:0];
    end

    assign o_result = r_res;

endmodule

>>> hdl/vector_add_relu_avg_pool.sv
// Add mode: the sum is registered at the accepting edge, then loaded into the output
// register; no new word is taken until then. Pool mode: a word that closes no window
// passes through the accumulate state back to idle; one that closes a window then
// waits for the 40-step bit-serial divider by the window area and the output register.
// One word in flight; a result parked in the output register frees the input side.
// i_rst_n is synchronous, active low: registers return to their reset values and
// positions to zero; partial sums are cleared at each window's first element.
module vector_add_relu_avg_pool
    import varap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] first_value, [63:32] second_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] result_value
    output logic        m_axis_tlast   // job_done
);

    logic        r_mode, r_relu;
    logic [12:0] r_nch;
    logic [15:0] r_h;
    logic [10:0] r_w;
    logic [4:0]  r_kh, r_kw;
    logic        cfg_wr;
    t_cfg        cfg;
    t_cmd        cmd;
    t_sts        sts;
    logic        in_fire, out_load, out_last, ready;
    logic [31:0] dp_res;
    logic        r_ovalid, r_olast;
    logic [31:0] r_odata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ADD; r_relu <= 1'b0;
            r_nch <= 13'd1; r_h <= 16'd1; r_w <= 11'd1; r_kh <= 5'd1; r_kw <= 5'd1;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_MODE:     r_mode <= pwdata[0];
                REG_CHANNELS: r_nch  <= pwdata[12:0];
                REG_HEIGHT:   r_h    <= pwdata[15:0];
                REG_WIDTH:    r_w    <= pwdata[10:0];
                REG_WIN_H:    r_kh   <= pwdata[4:0];
                REG_WIN_W:    r_kw   <= pwdata[4:0];
                REG_RELU:     r_relu <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MODE:     prdata = 32'(r_mode);
            REG_CHANNELS: prdata = 32'(r_nch);
            REG_HEIGHT:   prdata = 32'(r_h);
            REG_WIDTH:    prdata = 32'(r_w);
            REG_WIN_H:    prdata = 32'(r_kh);
            REG_WIN_W:    prdata = 32'(r_kw);
            REG_RELU:     prdata = 32'(r_relu);
            default:      prdata = '0;
        endcase
    end

    // Apply zero and saturation clamps once, here.
    always_comb begin
        cfg.mode = r_mode;
        cfg.relu = r_relu;
        cfg.nch  = 13'(clamp16(16'(r_nch), 16'(MAX_CHANNELS)));
        cfg.h    = clamp16(r_h, 16'hFFFF);
        cfg.w    = 11'(clamp16(16'(r_w), 16'(MAX_WIDTH)));
        cfg.kh   = 5'(clamp16(16'(r_kh), 16'(MAX_WINDOW)));
        cfg.kw   = 5'(clamp16(16'(r_kw), 16'(MAX_WINDOW)));
    end

    assign s_axis_tready = ready;
    assign in_fire = s_axis_tvalid && ready;

    varap_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg), .i_cfg_wr(cfg_wr),
        .i_in_fire(in_fire), .i_out_free(!r_ovalid || m_axis_tready), .i_sts(sts),
        .o_ready(ready), .o_out_load(out_load), .o_out_last(out_last), .o_cmd(cmd)
    );

    varap_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg), .i_cmd(cmd),
        .i_a(s_axis_tdata[31:0]), .i_b(s_axis_tdata[63:32]),
        .o_sts(sts), .o_result(dp_res)
    );

    // Output register: hold the word until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_odata <= dp_res;
            r_olast <= out_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

endmodule

>>> hdl/varap_checker.sv
module varap_checker
    import varap_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        pready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped while stalled");

    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while one in flight");

    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind vector_add_relu_avg_pool varap_checker u_chk (.*);
